/* rtl/mlt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types and constants of the multimap list table.
// ----------------------------------------------------------------------------
package mlt_pkg;
	localparam int MAX_KEYS           = 16;
	localparam int MAX_VALUES_PER_KEY = 16;
	localparam int KW  = $clog2(MAX_KEYS);
	localparam int SW  = $clog2(MAX_VALUES_PER_KEY);
	localparam int LW  = SW + 1;
	localparam int CW  = $clog2(MAX_VALUES_PER_KEY + 1);
	localparam int SLOTS = MAX_KEYS * MAX_VALUES_PER_KEY;
	localparam int AW  = $clog2(SLOTS);
	localparam int PW  = 9;
	localparam logic [LW-1:0] NULL_LINK = LW'(MAX_VALUES_PER_KEY);
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NO_KEY    = 2'd1,
		ST_NO_VALUE  = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] found_value;
		logic [1:0]         status;
		logic               last;
		logic [PW-1:0]      total_pairs;
	} out_item_t;

	// classified command held by mlt_back
	typedef struct packed {
		logic [1:0]         opcode;
		logic               hit;
		logic               room;
		logic [KW-1:0]      row;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} cmd_t;
endpackage

/* rtl/mlt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_in_if / mlt_out_if
// Valid-ready channels of the multimap list table.
// ----------------------------------------------------------------------------
interface mlt_in_if;
	import mlt_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mlt_out_if;
	import mlt_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/mlt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/mlt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_front
// Accept input transactions and push them into a short command queue.
// ----------------------------------------------------------------------------
module mlt_front (
	input  logic            clk,
	input  logic            arst_n,
	mlt_in_if.sink          in_ch,
	output mlt_pkg::in_item_t q_data,
	output logic            q_valid,
	input  logic            q_pop
);
	import mlt_pkg::*;

	localparam int QW = $clog2(QDEPTH);

	in_item_t      fifo_q [QDEPTH];
	logic [QW-1:0] wp_q, rp_q;
	logic [QW:0]   cnt_q;
	logic          push;

	assign in_ch.ready = (cnt_q != (QW+1)'(QDEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != '0);
	assign q_data      = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(q_pop);
		end
	end
endmodule

/* rtl/mlt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_back
// Classify a queued command against the key table and carry it out,
// walking value lists one RAM access per step.
// ----------------------------------------------------------------------------
module mlt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mlt_pkg::in_item_t q_data,
	input  logic              q_valid,
	output logic              q_pop,
	mlt_out_if.source         out_ch
);
	import mlt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_EXEC, S_RD, S_CHK, S_UNLINK, S_EMIT
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;

	logic signed [31:0] key_q  [MAX_KEYS];
	logic [MAX_KEYS-1:0] used_q;
	logic [LW-1:0] head_q [MAX_KEYS];
	logic [LW-1:0] free_q [MAX_KEYS];
	logic [CW-1:0] vcnt_q [MAX_KEYS];
	logic [PW-1:0] pairs_q;

	logic [LW-1:0] cur_q, prev_q;
	logic [CW-1:0] n_q;
	logic [SW-1:0] init_q;

	// RAMs
	logic          vwe, lwe;
	logic [AW-1:0] vwa, lwa, ra;
	logic [31:0]   vwd, vrd;
	logic [LW-1:0] lwd, lrd;

	mlt_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_val (
		.clk(clk), .we(vwe), .waddr(vwa), .wdata(vwd), .raddr(ra), .rdata(vrd));
	mlt_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link (
		.clk(clk), .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(ra), .rdata(lrd));

	// key match and free row search
	logic          hit, room;
	logic [KW-1:0] hrow, frow;
	always_comb begin
		hit = 1'b0; hrow = '0; room = 1'b0; frow = '0;
		for (int k = MAX_KEYS - 1; k >= 0; k--) begin
			if (used_q[k] && key_q[k] == q_data.key) begin
				hit = 1'b1; hrow = KW'(k);
			end
			if (!used_q[k]) begin
				room = 1'b1; frow = KW'(k);
			end
		end
	end

	function automatic logic [AW-1:0] addr(input logic [KW-1:0] r, input logic [LW-1:0] s);
		return {r, s[SW-1:0]};
	endfunction

	logic [KW-1:0] r;
	assign r = cmd_q.row;

	always_comb begin
		vwe = 1'b0; lwe = 1'b0;
		vwa = addr(r, cur_q); vwd = cmd_q.value;
		lwa = addr(r, cur_q); lwd = head_q[r];
		ra  = addr(r, cur_q);
		unique case (state_q)
			S_INIT: begin
				lwe = 1'b1; lwa = {r, init_q};
				lwd = LW'(init_q) + 1'b1;
			end
			S_CHK: begin
				if (cmd_q.opcode == OP_ADD) begin
					// taken slot gets the value and links to the old head
					vwe = 1'b1; lwe = 1'b1;
				end else if (cmd_q.opcode == OP_REMOVE && vrd == cmd_q.value) begin
					lwe = 1'b1;
					lwd = free_q[r];
				end
			end
			S_UNLINK: begin
				lwe = 1'b1;
				lwa = addr(r, prev_q);
				lwd = cur_q;
			end
			default: ;
		endcase
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			pairs_q      <= '0;
			out_ch.valid <= 1'b0;
			for (int k = 0; k < MAX_KEYS; k++) begin
				head_q[k] <= NULL_LINK;
				free_q[k] <= '0;
				vcnt_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q.opcode <= q_data.opcode;
						cmd_q.key    <= q_data.key;
						cmd_q.value  <= q_data.value;
						cmd_q.hit    <= hit;
						cmd_q.room   <= room;
						cmd_q.row    <= hit ? hrow : frow;
						cur_q  <= hit ? head_q[hrow] : NULL_LINK;
						prev_q <= NULL_LINK;
						n_q    <= '0;
						init_q <= '0;
						if (q_data.opcode == OP_ADD && !hit && room) begin
							state_q <= S_INIT;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == SW'(MAX_VALUES_PER_KEY - 1)) begin
						key_q[r]  <= cmd_q.key;
						used_q[r] <= 1'b1;
						head_q[r] <= NULL_LINK;
						free_q[r] <= '0;
						vcnt_q[r] <= '0;
						cmd_q.hit <= 1'b1;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					out_ch.data.found_value <= '0;
					out_ch.data.last        <= 1'b1;
					out_ch.data.total_pairs <= pairs_q;
					unique case (cmd_q.opcode) inside
						OP_ADD: begin
							if (cmd_q.hit && free_q[r] < NULL_LINK &&
							    vcnt_q[r] < CW'(MAX_VALUES_PER_KEY)) begin
								// fetch the link of the free head slot
								cur_q   <= free_q[r];
								state_q <= S_RD;
							end else begin
								out_ch.data.status <= ST_FULL;
								out_ch.valid <= 1'b1;
								state_q <= S_EMIT;
							end
						end
						OP_REMOVE, OP_SEARCH: begin
							if (!cmd_q.hit) begin
								out_ch.data.status <= ST_NO_KEY;
								out_ch.valid <= 1'b1;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_RD;
							end
						end
						default: begin
							out_ch.data.status <= ST_DONE;
							out_ch.valid <= 1'b1;
							state_q <= S_EMIT;
						end
					endcase
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					unique case (cmd_q.opcode)
						OP_ADD: begin
							head_q[r] <= cur_q;
							free_q[r] <= lrd;
							vcnt_q[r] <= vcnt_q[r] + 1'b1;
							pairs_q   <= pairs_q + 1'b1;
							out_ch.data.status      <= ST_DONE;
							out_ch.data.total_pairs <= pairs_q + 1'b1;
							out_ch.valid <= 1'b1;
							state_q <= S_EMIT;
						end
						OP_REMOVE: begin
							if (vrd == cmd_q.value) begin
								free_q[r] <= cur_q;
								vcnt_q[r] <= vcnt_q[r] - 1'b1;
								pairs_q   <= pairs_q - 1'b1;
								if (vcnt_q[r] == CW'(1)) used_q[r] <= 1'b0;
								out_ch.data.status      <= ST_DONE;
								out_ch.data.total_pairs <= pairs_q - 1'b1;
								if (prev_q == NULL_LINK) begin
									head_q[r] <= lrd;
									out_ch.valid <= 1'b1;
									state_q <= S_EMIT;
								end else begin
									// relink the predecessor next cycle
									cur_q   <= lrd;
									state_q <= S_UNLINK;
								end
							end else if (lrd >= NULL_LINK ||
							             n_q == CW'(MAX_VALUES_PER_KEY - 1)) begin
								out_ch.data.status      <= ST_NO_VALUE;
								out_ch.data.total_pairs <= pairs_q;
								out_ch.valid <= 1'b1;
								state_q <= S_EMIT;
							end else begin
								prev_q <= cur_q; cur_q <= lrd; n_q <= n_q + 1'b1;
								state_q <= S_RD;
							end
						end
						default: begin
							out_ch.data.found_value <= vrd;
							out_ch.data.status      <= ST_DONE;
							out_ch.data.total_pairs <= pairs_q;
							out_ch.data.last <= (lrd >= NULL_LINK ||
								n_q == CW'(MAX_VALUES_PER_KEY - 1));
							out_ch.valid <= 1'b1;
							prev_q <= cur_q; cur_q <= lrd; n_q <= n_q + 1'b1;
							state_q <= S_EMIT;
						end
					endcase
				end
				S_UNLINK: begin
					out_ch.valid <= 1'b1;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_ch.valid && out_ch.ready) begin
						out_ch.valid <= 1'b0;
						if (out_ch.data.last) state_q <= S_IDLE;
						else state_q <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/multimap_list_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multimap_list_table_top
// Key to multiple-value table with per-key linked value lists.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   opcode, key, value
// out_ch    out  found_value, status, last, total_pairs
//
// Add of a known key runs from queue pop to result through classify, check
// room, read the free link, write and emit; a new key first builds its row
// free list. Remove reads and checks each list slot in turn, with one more
// step to relink a slot that is not the head. Search emits one result per value.
// Reset clears key valid bits and counts at once; the slot RAMs need no
// clearing. A two-entry queue lets input stall apart from a stalled output.
// ----------------------------------------------------------------------------
module multimap_list_table_top (
	input logic clk,
	input logic arst_n,
	mlt_in_if.sink    in_ch,
	mlt_out_if.source out_ch
);
	import mlt_pkg::*;

	in_item_t q_data;
	logic     q_valid, q_pop;

	// accept and queue
	mlt_front u_front (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop));

	// execute
	mlt_back u_back (.clk(clk), .arst_n(arst_n), .q_data(q_data),
		.q_valid(q_valid), .q_pop(q_pop), .out_ch(out_ch));

	// pair count never exceeds capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.data.total_pairs <= PW'(SLOTS))
		else $error("pair count overflow");
	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
		else $error("result changed under stall");
	// a search hit carries done status
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.found_value != 0 |-> out_ch.data.status == ST_DONE)
		else $error("value with bad status");
endmodule

/* sim/tb_multimap_list_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multimap_list_table_top
// Self-checking bench for the multimap list table.
// Drives add, remove, search and no-op transactions through the input channel,
// predicts every result with a behavioral copy of the table and checks the
// output channel in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_multimap_list_table_top;
	import mlt_pkg::*;

	localparam int NROW = MAX_KEYS;
	localparam int NVAL = MAX_VALUES_PER_KEY;

	logic clk;
	logic arst_n;

	mlt_in_if  in_ch ();
	mlt_out_if out_ch ();

	multimap_list_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// Table model: each row holds its key and its values newest first.
	// The slot-level layout inside the block is not visible at the outputs,
	// so a plain ordered list per row predicts the same results.
	logic [31:0] row_key  [NROW];
	logic        row_used [NROW];
	logic [31:0] row_vals [NROW][$];
	int unsigned pairs_stored;

	out_item_t expected_results[$];
	int        error_count;

	// Pool of keys so that random traffic hits known keys often.
	logic [31:0] key_pool[$];

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic int find_row(logic [31:0] k);
		for (int r = 0; r < NROW; r++)
			if (row_used[r] && row_key[r] == k) return r;
		return -1;
	endfunction

	function automatic out_item_t make_result(logic [31:0] fv, status_t st, logic lst);
		out_item_t o;
		o.found_value = fv;
		o.status      = st;
		o.last        = lst;
		o.total_pairs = PW'(pairs_stored);
		return o;
	endfunction

	function automatic void queue_result(out_item_t o);
		expected_results.insert(expected_results.size(), o);
	endfunction

	// Apply one transaction to the table and queue the results it causes.
	function automatic void predict_table(in_item_t it);
		int      r;
		int      j;
		status_t st;
		r  = find_row(it.key);
		st = ST_DONE;
		case (op_t'(it.opcode))
			OP_ADD: begin
				if (r < 0) begin
					j = -1;
					for (int q = NROW - 1; q >= 0; q--)
						if (!row_used[q]) j = q;
					if (j < 0) st = ST_FULL;
					else begin
						row_used[j] = 1'b1;
						row_key[j]  = it.key;
						row_vals[j].delete();
						r = j;
					end
				end
				if (st == ST_DONE) begin
					if (row_vals[r].size() >= NVAL) st = ST_FULL;
					else begin
						row_vals[r].push_front(it.value);
						pairs_stored++;
					end
				end
				queue_result(make_result('0, st, 1'b1));
			end
			OP_REMOVE: begin
				if (r < 0) st = ST_NO_KEY;
				else begin
					st = ST_NO_VALUE;
					for (int i = 0; i < row_vals[r].size(); i++)
						if (row_vals[r][i] == it.value) begin
							row_vals[r].delete(i);
							pairs_stored--;
							st = ST_DONE;
							break;
						end
					if (row_vals[r].size() == 0) row_used[r] = 1'b0;
				end
				queue_result(make_result('0, st, 1'b1));
			end
			OP_SEARCH: begin
				if (r < 0 || row_vals[r].size() == 0)
					queue_result(make_result('0, ST_NO_KEY, 1'b1));
				else
					foreach (row_vals[r][i])
						queue_result(make_result(row_vals[r][i], ST_DONE,
							i == row_vals[r].size() - 1));
			end
			default: queue_result(make_result('0, ST_DONE, 1'b1));
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic int random_gap();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 10) return 0;
		if (sel < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Send one transaction; valid stays high into the next one unless a gap follows.
	task automatic send_item(op_t op, logic [31:0] k, logic [31:0] v);
		int gap;
		gap = random_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.data.opcode <= op;
		in_ch.data.key    <= k;
		in_ch.data.value  <= v;
		in_ch.valid       <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		predict_table('{opcode: op, key: k, value: v});
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Output side: random stalls, then compare each transaction in order.
	initial begin
		out_item_t got;
		out_item_t want;
		int        stall_left;
		stall_left   = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected_results.size() == 0)
					report_mismatch("unexpected result", 64'(got), 64'(0));
				else begin
					want = expected_results.pop_front();
					if (got.found_value !== want.found_value)
						report_mismatch("found_value", 64'(got.found_value),
							64'(want.found_value));
					if (got.status !== want.status)
						report_mismatch("status", 64'(got.status), 64'(want.status));
					if (got.last !== want.last)
						report_mismatch("last", 64'(got.last), 64'(want.last));
					if (got.total_pairs !== want.total_pairs)
						report_mismatch("total_pairs", 64'(got.total_pairs),
							64'(want.total_pairs));
				end
			end
			// Hold ready low for a random stretch, mostly short, sometimes long.
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				stall_left = random_gap();
				out_ch.ready <= (stall_left == 0);
			end
		end
	end

	task automatic test_extremes();
		send_item(OP_SEARCH, 32'h8000_0000, 32'h0);
		send_item(OP_REMOVE, 32'h7FFF_FFFF, 32'h1);
		send_item(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(OP_ADD, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_ADD, 32'h0, 32'h0);
		send_item(OP_SEARCH, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(OP_NOP, 32'h7FFF_FFFF, 32'h5555_AAAA);
		send_item(OP_REMOVE, 32'h8000_0000, 32'h1234);
		send_item(OP_REMOVE, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
	endtask

	task automatic test_duplicates_and_full_row();
		send_item(OP_ADD, 32'd5, 32'd9);
		send_item(OP_ADD, 32'd5, 32'd7);
		send_item(OP_ADD, 32'd5, 32'd9);
		send_item(OP_REMOVE, 32'd5, 32'd9);
		send_item(OP_SEARCH, 32'd5, 32'd0);
		for (int i = 0; i < NVAL + 1; i++) send_item(OP_ADD, 32'd77, 32'(i * 3));
		send_item(OP_SEARCH, 32'd77, 32'd0);
		wait_drained();
	endtask

	task automatic test_full_table();
		for (int i = 0; i < NROW + 1; i++) send_item(OP_ADD, 32'(1000 + i), 32'(i));
		send_item(OP_SEARCH, 32'(1000 + NROW), 32'd0);
		// Release rows again so later traffic has room.
		for (int i = 0; i < NROW; i++) send_item(OP_REMOVE, 32'(1000 + i), 32'(i));
		send_item(OP_REMOVE, 32'd77, 32'd0);
	endtask

	task automatic test_random_traffic(int count);
		logic [31:0] k;
		logic [31:0] v;
		int          sel;
		for (int i = 0; i < 8; i++) key_pool.insert(key_pool.size(), $urandom);
		key_pool.insert(key_pool.size(), 32'h8000_0000);
		key_pool.insert(key_pool.size(), 32'h7FFF_FFFF);
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			k = ($urandom_range(0, 9) == 0) ? $urandom
				: key_pool[$urandom_range(0, key_pool.size() - 1)];
			v = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 7));
			if (sel < 45) send_item(OP_ADD, k, v);
			else if (sel < 70) send_item(OP_REMOVE, k, v);
			else if (sel < 95) send_item(OP_SEARCH, k, v);
			else send_item(OP_NOP, k, v);
		end
	endtask

	initial begin
		error_count  = 0;
		pairs_stored = 0;
		for (int r = 0; r < NROW; r++) row_used[r] = 1'b0;
		arst_n      = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_duplicates_and_full_row();
		test_full_table();
		test_random_traffic(90);

		wait_drained();
		if (error_count == 0)
			$display("multimap_list_table_top test passed");
		else
			$display("multimap_list_table_top test failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("multimap_list_table_top test failed");
		$finish;
	end
endmodule

/* multimap_list_table_top.f */
rtl/mlt_pkg.sv
rtl/mlt_if.sv
rtl/mlt_ram.sv
rtl/mlt_front.sv
rtl/mlt_back.sv
rtl/multimap_list_table_top.sv
sim/tb_multimap_list_table_top.sv
